>>> rtl/core/tcw_pkg.sv
// Shared constants, types and helper functions for the text console writer.
package tcw_pkg;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);

    localparam int COL_W   = 7;
    localparam int ROW_W   = 5;
    localparam int CHAR_W  = 8;
    localparam int ATTR_W  = 8;
    localparam int CELL_W  = 16;
    localparam int POS_W   = 11;
    localparam int OP_W    = 2;
    // row times a column count of up to 128, plus a column
    localparam int LIN_W   = ROW_W + COL_W + 1;

    localparam logic [OP_W-1:0]   OP_PUT    = 2'd0;
    localparam logic [OP_W-1:0]   OP_SET    = 2'd1;
    localparam logic [OP_W-1:0]   OP_CLEAR  = 2'd2;
    localparam logic [OP_W-1:0]   OP_READ   = 2'd3;

    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
    localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;
    localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'hF0;

    localparam logic [ADDR_W-1:0] LAST_ADDR   = ADDR_W'(CELL_COUNT - 1);
    localparam logic [ADDR_W-1:0] SCROLL_LAST = ADDR_W'(CELL_COUNT - COLUMNS);
    localparam logic [ADDR_W-1:0] ROW_STRIDE  = ADDR_W'(COLUMNS);

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_FILL,
        ST_SCROLL,
        ST_READ,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [POS_W-1:0]  cursor_pos;
        logic [CELL_W-1:0] cell_value;
        logic              scrolled;
    } result_t;

    function automatic logic [LIN_W-1:0] lin_index(input logic [COL_W-1:0] c,
                                                   input logic [ROW_W-1:0] r);
        lin_index = LIN_W'(r) * LIN_W'(COLUMNS) + LIN_W'(c);
    endfunction

    function automatic logic [COL_W-1:0] clamp_col(input logic [COL_W-1:0] c);
        clamp_col = ({1'b0, c} >= (COL_W+1)'(COLUMNS)) ? COL_W'(COLUMNS - 1) : c;
    endfunction

    function automatic logic [ROW_W-1:0] clamp_row(input logic [ROW_W-1:0] r);
        clamp_row = ({1'b0, r} >= (ROW_W+1)'(ROWS)) ? ROW_W'(ROWS - 1) : r;
    endfunction

endpackage

>>> rtl/core/text_console_writer.sv
// Text console writer: 80x25 text screen engine with a streaming command port.
//
// Commands arrive on s_axis_*: tuser carries the op (put, set cursor, clear,
// read cell), tdata the character, column, row and clear attribute. Every
// command gives exactly one result transfer on m_axis_*: the linear cursor
// position, the cell read (read op only) and a scroll flag.
// cfg_we/cfg_wdata write the text attribute used by put; write it while idle.
//
// Result path per command:
//   put without scroll, set cursor : from the idle state through the output register
//   read cell                      : one memory read, then the done state
//   put with scroll                : row copy sweep, then the done state
//   clear                          : fill sweep of every cell, then the done state
// One command is in flight at a time; the screen memory's single write port
// sets the sweep lengths. A result waits in the output register while
// m_axis_tready is low, and a new command is taken once that register drains.
// After reset every one of the COLUMNS*ROWS (2000) cells is swept to zero with
// s_axis_tready low; configuration writes are taken throughout.
module text_console_writer
    import tcw_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [ATTR_W-1:0] cfg_wdata,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // [7:0] char_code, [14:8] col, [19:15] row, [27:20] clear_attribute
    input  logic [31:0]       s_axis_tdata,
    // [1:0] op
    input  logic [OP_W-1:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // [10:0] cursor_pos, [26:11] cell_value, [27] scrolled
    output logic [31:0]       m_axis_tdata
);

    result_t           res;
    logic              res_valid;
    logic              res_ready;
    logic              out_valid_reg;
    result_t           out_reg;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [CELL_W-1:0] ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [CELL_W-1:0] ram_rdata;

    tcw_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (s_axis_tvalid),
        .in_ready      (s_axis_tready),
        .in_op         (s_axis_tuser),
        .in_char       (s_axis_tdata[7:0]),
        .in_col        (s_axis_tdata[14:8]),
        .in_row        (s_axis_tdata[19:15]),
        .in_clear_attr (s_axis_tdata[27:20]),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .res           (res),
        .ram_we        (ram_we),
        .ram_waddr     (ram_waddr),
        .ram_wdata     (ram_wdata),
        .ram_re        (ram_re),
        .ram_raddr     (ram_raddr),
        .ram_rdata     (ram_rdata)
    );

    tcw_screen_ram u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign res_ready = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0, out_reg.scrolled, out_reg.cell_value, out_reg.cursor_pos};

endmodule

>>> rtl/core/tcw_screen_ram.sv
// Screen store: one write port, one registered read port.
module tcw_screen_ram
    import tcw_pkg::*;
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [CELL_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [CELL_W-1:0] rdata
);

    logic [CELL_W-1:0] mem [CELL_COUNT];
    logic [CELL_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/tcw_ctrl.sv
// Console sequencer: cursor, put/set/read/clear, scroll and fill sweeps.
module tcw_ctrl
    import tcw_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [ATTR_W-1:0] cfg_wdata,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [OP_W-1:0]   in_op,
    input  logic [CHAR_W-1:0] in_char,
    input  logic [COL_W-1:0]  in_col,
    input  logic [ROW_W-1:0]  in_row,
    input  logic [ATTR_W-1:0] in_clear_attr,
    output logic              res_valid,
    input  logic              res_ready,
    output result_t           res,
    output logic              ram_we,
    output logic [ADDR_W-1:0] ram_waddr,
    output logic [CELL_W-1:0] ram_wdata,
    output logic              ram_re,
    output logic [ADDR_W-1:0] ram_raddr,
    input  logic [CELL_W-1:0] ram_rdata
);

    state_t            state_reg, state_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [ATTR_W-1:0] attr_reg;
    logic [ADDR_W-1:0] sweep_reg, sweep_next;
    logic [CELL_W-1:0] fill_reg, fill_next;
    logic              wr_pend_reg, wr_pend_next;
    logic [ADDR_W-1:0] wr_addr_reg, wr_addr_next;
    logic [CELL_W-1:0] cell_reg, cell_next;
    logic              scr_reg, scr_next;

    logic              accept;
    logic [COL_W:0]    put_col;
    logic [ROW_W:0]    put_row;
    logic [LIN_W-1:0]  cur_lin;
    logic [LIN_W-1:0]  next_lin;
    logic [LIN_W-1:0]  read_lin;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_INIT;
            col_reg     <= '0;
            row_reg     <= '0;
            attr_reg    <= ATTR_RESET;
            sweep_reg   <= '0;
            fill_reg    <= '0;
            wr_pend_reg <= 1'b0;
            scr_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            sweep_reg   <= sweep_next;
            fill_reg    <= fill_next;
            wr_pend_reg <= wr_pend_next;
            scr_reg     <= scr_next;
            if (cfg_we)
            begin
                attr_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        wr_addr_reg <= wr_addr_next;
        cell_reg    <= cell_next;
    end

    assign in_ready = (state_reg == ST_IDLE) && res_ready;
    assign accept   = in_valid && in_ready;
    assign cur_lin  = lin_index(col_reg, row_reg);
    assign next_lin = lin_index(col_next, row_next);
    assign read_lin = lin_index(clamp_col(in_col), clamp_row(in_row));

    always_comb
    begin
        state_next   = state_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        sweep_next   = sweep_reg;
        fill_next    = fill_reg;
        wr_pend_next = 1'b0;
        wr_addr_next = wr_addr_reg;
        cell_next    = cell_reg;
        scr_next     = scr_reg;
        ram_we       = 1'b0;
        ram_waddr    = sweep_reg;
        ram_wdata    = fill_reg;
        ram_re       = 1'b0;
        ram_raddr    = read_lin[ADDR_W-1:0];
        res_valid    = 1'b0;
        put_col      = {1'b0, col_reg} + 1'b1;
        put_row      = {1'b0, row_reg};

        case (state_reg)
            ST_INIT:
            begin
                ram_we     = 1'b1;
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == LAST_ADDR)
                begin
                    sweep_next = '0;
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (accept)
                begin
                    cell_next = '0;
                    scr_next  = 1'b0;
                    case (in_op)
                        OP_PUT:
                        begin
                            if (in_char == NEWLINE_CODE)
                            begin
                                put_col = '0;
                                put_row = {1'b0, row_reg} + 1'b1;
                            end
                            else
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = cur_lin[ADDR_W-1:0];
                                ram_wdata = {attr_reg, in_char};
                                if (put_col >= (COL_W+1)'(COLUMNS))
                                begin
                                    put_col = '0;
                                    put_row = {1'b0, row_reg} + 1'b1;
                                end
                            end
                            col_next = put_col[COL_W-1:0];
                            if (put_row >= (ROW_W+1)'(ROWS))
                            begin
                                row_next   = ROW_W'(ROWS - 1);
                                scr_next   = 1'b1;
                                sweep_next = '0;
                                state_next = ST_SCROLL;
                            end
                            else
                            begin
                                row_next  = put_row[ROW_W-1:0];
                                res_valid = 1'b1;
                            end
                        end
                        OP_SET:
                        begin
                            col_next  = clamp_col(in_col);
                            row_next  = clamp_row(in_row);
                            res_valid = 1'b1;
                        end
                        OP_CLEAR:
                        begin
                            col_next   = '0;
                            row_next   = '0;
                            fill_next  = {in_clear_attr, SPACE_CODE};
                            sweep_next = '0;
                            state_next = ST_FILL;
                        end
                        default:
                        begin
                            ram_re     = 1'b1;
                            state_next = ST_READ;
                        end
                    endcase
                end
            end

            ST_FILL:
            begin
                ram_we     = 1'b1;
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == LAST_ADDR)
                begin
                    sweep_next = '0;
                    state_next = ST_DONE;
                end
            end

            ST_SCROLL:
            begin
                // read one row ahead, write the cell fetched last cycle
                ram_waddr = wr_addr_reg;
                ram_wdata = ram_rdata;
                ram_we    = wr_pend_reg;
                ram_raddr = sweep_reg + ROW_STRIDE;
                if (sweep_reg != SCROLL_LAST)
                begin
                    ram_re       = 1'b1;
                    wr_pend_next = 1'b1;
                    wr_addr_next = sweep_reg;
                    sweep_next   = sweep_reg + 1'b1;
                end
                else
                begin
                    sweep_next = '0;
                    state_next = ST_DONE;
                end
            end

            ST_READ:
            begin
                cell_next  = ram_rdata;
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (state_reg == ST_DONE)
        begin
            res.cursor_pos = cur_lin[POS_W-1:0];
            res.cell_value = cell_reg;
            res.scrolled   = scr_reg;
        end
        else
        begin
            res.cursor_pos = next_lin[POS_W-1:0];
            res.cell_value = '0;
            res.scrolled   = 1'b0;
        end
    end

endmodule
